// ===== design/brl_pkg.sv =====
// ----------------------------------------------------------------------------
// brl_pkg: shared types and constants for the byte-range lock table
// Table geometry, request codes, status codes and the stored entry layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brl_pkg;

  localparam int LOCK_ENTRIES = 32;
  localparam int HANDLES      = 16;
  localparam int IDX_W        = (LOCK_ENTRIES > 1) ? $clog2(LOCK_ENTRIES) : 1;
  localparam int CNT_W        = $clog2(LOCK_ENTRIES + 1);
  localparam int HX_W         = (HANDLES > 1) ? $clog2(HANDLES) : 1;

  localparam logic [63:0] HIGH_START = 64'h0000_0000_ef00_0000;

  // request codes
  localparam logic [1:0] FN_LOCK   = 2'd0;
  localparam logic [1:0] FN_UNLOCK = 2'd1;
  localparam logic [1:0] FN_ACCESS = 2'd2;
  localparam logic [1:0] FN_PURGE  = 2'd3;

  localparam logic [1:0] KIND_READ = 2'd1;

  // status codes
  localparam logic [2:0] ST_SUCCESS     = 3'd0;
  localparam logic [2:0] ST_NOT_GRANTED = 3'd1;
  localparam logic [2:0] ST_CONFLICT    = 3'd2;
  localparam logic [2:0] ST_NOT_LOCKED  = 3'd3;
  localparam logic [2:0] ST_FULL        = 3'd4;

  typedef struct packed {
    logic [63:0] start;
    logic [63:0] length;
    logic        excl;
    logic [3:0]  handle;
    logic [15:0] session;
    logic [15:0] process;
    logic [15:0] user;
  } entry_t;

endpackage

`default_nettype wire

// ===== design/byte_range_lock_table_unit.sv =====
// ----------------------------------------------------------------------------
// byte_range_lock_table_unit
// Bounded byte-range lock table serving lock, unlock, access check and purge.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction
//  request | in_valid, in_stall, func ...    | in (in_stall out)
//  result  | out_valid, out_stall, status    | out (out_stall in)
//
//  Per request, every held entry (at most 32 held locks) is read once from the
//  table memory through one overlap/owner comparator, then S_FIN updates and
//  S_OUT presents the result.
//  Held locks sit in the low slots, oldest first; removals compact the table
//  during the same scan. Reset (rst, synchronous) empties the table.
//  A stalled result holds; no new request is taken until it leaves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module byte_range_lock_table_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [63:0] range_start,
  input  wire logic [63:0] range_length,
  input  wire logic [3:0]  file_handle,
  input  wire logic        handle_open,
  input  wire logic [15:0] session_id,
  input  wire logic [15:0] process_id,
  input  wire logic [15:0] user_id,
  input  wire logic        exclusive,
  input  wire logic [1:0]  access_kind,
  output      logic        out_valid,
  input  wire logic        out_stall,
  output      logic [2:0]  status
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN, S_OUT} state_t;

  state_t state;

  // latched request
  logic [1:0]  r_func;
  logic [63:0] r_start, r_len, r_end;
  logic [3:0]  r_fh;
  logic        r_open, r_excl;
  logic [15:0] r_ses, r_pid, r_uid;
  logic [1:0]  r_kind;

  // table memory and fill count
  brl_pkg::entry_t mem [brl_pkg::LOCK_ENTRIES];
  brl_pkg::entry_t rdata;
  logic [brl_pkg::CNT_W-1:0] cnt, ra, wp;
  logic ev, hit, found;

  // failure memory
  logic [63:0] lf_start [brl_pkg::HANDLES];
  logic [brl_pkg::HANDLES-1:0] lf_valid;

  logic                      we;
  logic [brl_pkg::IDX_W-1:0] wa;
  brl_pkg::entry_t           wd;

  logic [brl_pkg::HX_W-1:0] hx;
  logic [63:0] lend;
  logic overlap, same, lock_block, acc_block, match, drop;

  assign hx = r_fh[brl_pkg::HX_W-1:0];

  // overlap and owner compare on the entry read last cycle
  always_comb begin
    lend    = rdata.start + rdata.length;
    overlap = 1'b0;
    if (r_len != 64'd0 && rdata.length != 64'd0) begin
      if (r_start < rdata.start) begin
        if (r_end > rdata.start) overlap = 1'b1;
      end else if (r_start < lend) begin
        overlap = 1'b1;
      end
      if (r_end > lend) begin
        if (r_start < lend) overlap = 1'b1;
      end else if (r_end > rdata.start) begin
        overlap = 1'b1;
      end
    end
    same = rdata.handle == r_fh && rdata.session == r_ses &&
           rdata.process == r_pid && rdata.user == r_uid;
    lock_block = overlap && (rdata.excl || r_excl) && !(!r_excl && rdata.excl && same);
    acc_block  = overlap && !(!rdata.excl && r_kind == brl_pkg::KIND_READ) &&
                 !(rdata.excl && rdata.session == r_ses && rdata.process == r_pid);
    match = same && rdata.start == r_start && rdata.length == r_len;
    drop  = (r_func == brl_pkg::FN_UNLOCK && match && !found) ||
            (r_func == brl_pkg::FN_PURGE && rdata.handle == r_fh);
  end

  // single write port: compaction during scan, append at finish
  always_comb begin
    we = 1'b0;
    wa = wp[brl_pkg::IDX_W-1:0];
    wd = rdata;
    if (state == S_SCAN && ev && !drop &&
        (r_func == brl_pkg::FN_UNLOCK || r_func == brl_pkg::FN_PURGE)) begin
      we = 1'b1;
    end else if (state == S_FIN && r_func == brl_pkg::FN_LOCK && r_open && !hit &&
                 cnt != brl_pkg::CNT_W'(brl_pkg::LOCK_ENTRIES)) begin
      we = 1'b1;
      wa = cnt[brl_pkg::IDX_W-1:0];
      wd = '{start: r_start, length: r_len, excl: r_excl, handle: r_fh,
             session: r_ses, process: r_pid, user: r_uid};
    end
  end

  // table memory
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata <= mem[ra[brl_pkg::IDX_W-1:0]];
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      lf_valid <= '0;
      ev       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            r_func  <= func;
            r_start <= range_start;
            r_len   <= range_length;
            r_end   <= range_start + range_length;
            r_fh    <= file_handle;
            r_open  <= handle_open;
            r_excl  <= exclusive;
            r_ses   <= session_id;
            r_pid   <= process_id;
            r_uid   <= user_id;
            r_kind  <= access_kind;
            ra      <= '0;
            wp      <= '0;
            ev      <= 1'b0;
            hit     <= 1'b0;
            found   <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (ra < cnt) begin
            ra <= ra + 1'b1;
            ev <= 1'b1;
          end else begin
            ev <= 1'b0;
          end
          if (ev) begin
            if (r_func == brl_pkg::FN_LOCK && lock_block) hit <= 1'b1;
            if (r_func == brl_pkg::FN_ACCESS && acc_block) hit <= 1'b1;
            if (r_func == brl_pkg::FN_UNLOCK && match) found <= 1'b1;
            if (!drop) wp <= wp + 1'b1;
          end else if (ra >= cnt) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_OUT;
          case (r_func)
            brl_pkg::FN_LOCK: begin
              if (!r_open) begin
                status        <= brl_pkg::ST_NOT_LOCKED;
                lf_start[hx]  <= r_start;
                lf_valid[hx]  <= 1'b1;
              end else if (hit) begin
                if ((r_start >= brl_pkg::HIGH_START && !r_start[63]) ||
                    (lf_valid[hx] && lf_start[hx] == r_start))
                  status <= brl_pkg::ST_CONFLICT;
                else
                  status <= brl_pkg::ST_NOT_GRANTED;
                lf_start[hx] <= r_start;
                lf_valid[hx] <= 1'b1;
              end else if (cnt == brl_pkg::CNT_W'(brl_pkg::LOCK_ENTRIES)) begin
                status <= brl_pkg::ST_FULL;
              end else begin
                status <= brl_pkg::ST_SUCCESS;
                cnt    <= cnt + 1'b1;
              end
            end
            brl_pkg::FN_UNLOCK: begin
              status <= found ? brl_pkg::ST_SUCCESS : brl_pkg::ST_NOT_LOCKED;
              cnt    <= wp;
            end
            brl_pkg::FN_ACCESS: begin
              status <= hit ? brl_pkg::ST_CONFLICT : brl_pkg::ST_SUCCESS;
            end
            default: begin
              status <= brl_pkg::ST_SUCCESS;
              cnt    <= wp;
            end
          endcase
        end
        S_OUT: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_byte_range_lock_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_byte_range_lock_table_unit
// Drives lock, unlock, access check and purge requests with random gaps and
// result stalls; a scoreboard predicts the lock table status per request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Predicts the status of each accepted request and checks the results.
class lock_scoreboard;

  brl_pkg::entry_t tbl[brl_pkg::LOCK_ENTRIES];
  bit              held[brl_pkg::LOCK_ENTRIES];
  logic [63:0]     fail_start[brl_pkg::HANDLES];
  bit              fail_ok[brl_pkg::HANDLES];
  logic [2:0]      pending[$];
  int              errors;

  function new();
    errors = 0;
    for (int i = 0; i < brl_pkg::LOCK_ENTRIES; i++) held[i] = 0;
    for (int i = 0; i < brl_pkg::HANDLES; i++) fail_ok[i] = 0;
  endfunction

  // overlap test with wrapping end sums
  function bit meets(int i, logic [63:0] s, logic [63:0] len);
    logic [63:0] ls, ll, rend, lend;
    ls = tbl[i].start;
    ll = tbl[i].length;
    rend = s + len;
    lend = ls + ll;
    if (len == 0 || ll == 0) return 0;
    if (s < ls) begin
      if (rend > ls) return 1;
    end else if (s < lend) return 1;
    if (rend > lend) begin
      if (s < lend) return 1;
    end else if (rend > ls) return 1;
    return 0;
  endfunction

  function void drop(int i);
    for (int k = i; k + 1 < brl_pkg::LOCK_ENTRIES; k++) begin
      held[k] = held[k + 1];
      tbl[k] = tbl[k + 1];
    end
    held[brl_pkg::LOCK_ENTRIES - 1] = 0;
  endfunction

  function void note_request(logic [1:0] fn, logic [63:0] s, logic [63:0] len,
                             logic [3:0] fh, logic op, logic [15:0] ses,
                             logic [15:0] pid, logic [15:0] uid, logic ex,
                             logic [1:0] kind);
    logic [2:0] st;
    bit same;
    int i, hx;
    st = brl_pkg::ST_SUCCESS;
    hx = fh % brl_pkg::HANDLES;
    case (fn)
      brl_pkg::FN_LOCK: begin
        if (!op) st = brl_pkg::ST_NOT_LOCKED;
        else begin
          for (i = 0; i < brl_pkg::LOCK_ENTRIES; i++) begin
            if (!held[i] || !meets(i, s, len)) continue;
            if (!tbl[i].excl && !ex) continue;
            same = tbl[i].handle == fh && tbl[i].session == ses &&
                   tbl[i].process == pid && tbl[i].user == uid;
            if (!ex && tbl[i].excl && same) continue;
            st = brl_pkg::ST_NOT_GRANTED;
            break;
          end
          if (st == brl_pkg::ST_NOT_GRANTED) begin
            if (s >= brl_pkg::HIGH_START && !s[63]) st = brl_pkg::ST_CONFLICT;
            if (fail_ok[hx] && fail_start[hx] == s) st = brl_pkg::ST_CONFLICT;
          end
        end
        if (st != brl_pkg::ST_SUCCESS) begin
          fail_start[hx] = s;
          fail_ok[hx] = 1;
        end else begin
          for (i = 0; i < brl_pkg::LOCK_ENTRIES && held[i]; i++) ;
          if (i >= brl_pkg::LOCK_ENTRIES) st = brl_pkg::ST_FULL;
          else begin
            held[i] = 1;
            tbl[i] = '{s, len, ex, fh, ses, pid, uid};
          end
        end
      end
      brl_pkg::FN_UNLOCK: begin
        st = brl_pkg::ST_NOT_LOCKED;
        for (i = 0; i < brl_pkg::LOCK_ENTRIES; i++)
          if (held[i] && tbl[i].start == s && tbl[i].length == len &&
              tbl[i].handle == fh && tbl[i].session == ses &&
              tbl[i].process == pid && tbl[i].user == uid) begin
            drop(i);
            st = brl_pkg::ST_SUCCESS;
            break;
          end
      end
      brl_pkg::FN_ACCESS: begin
        for (i = 0; i < brl_pkg::LOCK_ENTRIES; i++) begin
          if (!held[i] || !meets(i, s, len)) continue;
          if (!tbl[i].excl && kind == brl_pkg::KIND_READ) continue;
          if (tbl[i].excl && tbl[i].session == ses && tbl[i].process == pid)
            continue;
          st = brl_pkg::ST_CONFLICT;
          break;
        end
      end
      default: begin
        i = 0;
        while (i < brl_pkg::LOCK_ENTRIES)
          if (held[i] && tbl[i].handle == fh) drop(i);
          else i++;
      end
    endcase
    pending.push_back(st);
  endfunction

  function void check_status(logic [2:0] got);
    logic [2:0] want;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result status=%0d", $time, got);
      errors++;
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      $display("%0t: status mismatch expected=%0d actual=%0d", $time, want, got);
      errors++;
    end
  endfunction
endclass

module tb_byte_range_lock_table_unit;

  localparam int CYCLE_LIMIT = 400000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [63:0] range_start;
  logic [63:0] range_length;
  logic [3:0]  file_handle;
  logic        handle_open;
  logic [15:0] session_id;
  logic [15:0] process_id;
  logic [15:0] user_id;
  logic        exclusive;
  logic [1:0]  access_kind;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;

  lock_scoreboard sb;
  int  cycles;
  bit  calm;       // no idling on either side while set
  bit  done;

  // recently requested locks of owner zero, reused for later non-purge requests
  logic [63:0] used_start[$];
  logic [63:0] used_len[$];
  logic [3:0]  used_fh[$];

  byte_range_lock_table_unit uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side: random stall and checking
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_status(status);
    out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 19);
  end

  // one request; waits for acceptance
  task automatic send(logic [1:0] fn, logic [63:0] s, logic [63:0] len,
                      logic [3:0] fh, logic op, logic [15:0] ses,
                      logic [15:0] pid, logic [15:0] uid, logic ex,
                      logic [1:0] kind);
    while (!calm && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    func <= fn; range_start <= s; range_length <= len; file_handle <= fh;
    handle_open <= op; session_id <= ses; process_id <= pid; user_id <= uid;
    exclusive <= ex; access_kind <= kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(fn, s, len, fh, op, ses, pid, uid, ex, kind);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // random request, mostly small owner and range space to cause overlaps
  task automatic random_request();
    logic [1:0]  fn;
    logic [63:0] s, len;
    logic [3:0]  fh;
    logic [15:0] ses, pid, uid;
    int r, k;
    r = $urandom_range(0, 99);
    fn = (r < 45) ? brl_pkg::FN_LOCK :
         (r < 70) ? brl_pkg::FN_UNLOCK :
         (r < 92) ? brl_pkg::FN_ACCESS : brl_pkg::FN_PURGE;
    fh = 4'($urandom_range(0, 3));
    ses = 16'($urandom_range(0, 1));
    pid = 16'($urandom_range(0, 1));
    uid = 16'($urandom_range(0, 1));
    s = 64'($urandom_range(0, 200));
    len = 64'($urandom_range(0, 40));
    r = $urandom_range(0, 99);
    if (r < 8) begin
      s = {$urandom, $urandom};
      len = {$urandom, $urandom};
      fh = 4'($urandom); ses = 16'($urandom); pid = 16'($urandom); uid = 16'($urandom);
    end else if (r < 14) s = 64'hef00_0000 + 64'($urandom_range(0, 100));
    else if (r < 18) s = 64'hffff_ffff_ffff_ffc0 + 64'($urandom_range(0, 63));
    if (used_start.size() != 0 && $urandom_range(0, 99) < 50 &&
        fn != brl_pkg::FN_PURGE) begin
      k = $urandom_range(0, used_start.size() - 1);
      s = used_start[k]; len = used_len[k]; fh = used_fh[k];
      ses = 0; pid = 0; uid = 0;
    end
    if (fn == brl_pkg::FN_LOCK && $urandom_range(0, 2) == 0) begin
      ses = 0; pid = 0; uid = 0;
    end
    send(fn, s, len, fh, $urandom_range(0, 15) != 0, ses, pid, uid,
         1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    if (fn == brl_pkg::FN_LOCK && ses == 0 && pid == 0 && uid == 0) begin
      used_start.push_back(s); used_len.push_back(len); used_fh.push_back(fh);
      if (used_start.size() > 40) begin
        void'(used_start.pop_front()); void'(used_len.pop_front());
        void'(used_fh.pop_front());
      end
    end
  endtask

  initial begin
    int n;
    sb = new();
    cycles = 0;
    calm = 0;
    rst = 1;
    in_valid = 0; out_stall = 0;
    func = brl_pkg::FN_LOCK; range_start = 0; range_length = 0; file_handle = 0;
    handle_open = 0; session_id = 0; process_id = 0; user_id = 0;
    exclusive = 0; access_kind = 0;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: closed handle, shared/exclusive mix, same-owner upgrade
    send(brl_pkg::FN_LOCK, 100, 10, 1, 0, 1, 1, 1, 0, 1);
    send(brl_pkg::FN_LOCK, 100, 10, 1, 1, 1, 1, 1, 1, 1);
    send(brl_pkg::FN_LOCK, 105, 10, 1, 1, 1, 1, 1, 0, 1);
    send(brl_pkg::FN_LOCK, 105, 10, 2, 1, 1, 1, 1, 0, 1);
    send(brl_pkg::FN_LOCK, 105, 10, 2, 1, 1, 1, 1, 0, 1);
    send(brl_pkg::FN_LOCK, 100, 0, 2, 1, 1, 1, 1, 1, 1);
    send(brl_pkg::FN_ACCESS, 100, 5, 3, 1, 9, 9, 9, 0, 1);
    send(brl_pkg::FN_ACCESS, 100, 5, 3, 1, 1, 1, 9, 0, 2);
    send(brl_pkg::FN_ACCESS, 100, 5, 3, 1, 9, 9, 9, 0, 0);
    send(brl_pkg::FN_ACCESS, 100, 5, 3, 1, 9, 9, 9, 0, 3);
    // high start conflict, bit 63 set, wrapping ranges
    send(brl_pkg::FN_LOCK, 64'hef00_0000, 64'hffff_ffff_ffff_ffff, 4, 1, 0, 0, 0, 1, 1);
    send(brl_pkg::FN_LOCK, 64'hef00_0010, 16, 5, 1, 0, 0, 0, 1, 1);
    send(brl_pkg::FN_LOCK, 64'hffff_ffff_ffff_fff0, 64'h40, 6, 1, 16'hffff, 16'hffff,
         16'hffff, 1, 1);
    send(brl_pkg::FN_LOCK, 64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_ffff, 7, 1,
         0, 0, 0, 1, 1);
    send(brl_pkg::FN_LOCK, 8, 8, 15, 1, 0, 0, 0, 1, 1);
    send(brl_pkg::FN_UNLOCK, 100, 10, 1, 1, 1, 1, 1, 1, 1);
    send(brl_pkg::FN_UNLOCK, 100, 10, 1, 1, 1, 1, 1, 1, 1);
    send(brl_pkg::FN_PURGE, 0, 0, 2, 1, 0, 0, 0, 0, 1);
    send(brl_pkg::FN_PURGE, 0, 0, 4, 1, 0, 0, 0, 0, 1);
    // fill the table to full
    for (int i = 0; i < brl_pkg::LOCK_ENTRIES + 2; i++)
      send(brl_pkg::FN_LOCK, 64'(1000 + 2 * i), 1, 9, 1, 0, 0, 0, 0, 1);
    send(brl_pkg::FN_PURGE, 0, 0, 9, 1, 0, 0, 0, 0, 1);

    // sender hold-off until all results have come
    drain();

    for (n = 0; n < 1400; n++) begin
      calm = (n >= 600 && n < 750);
      if (n == 1000) drain();
      random_request();
    end
    calm = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
